// File: hdl/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; every other file imports this package.
package lr_pkg;

    localparam int FIELD_BITS     = 12;
    localparam int COLOUR_BITS    = 16;
    localparam int CFG_BITS       = 12;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [CFG_BITS-1:0] RESET_WIDTH  = 12'd480;
    localparam logic [CFG_BITS-1:0] RESET_HEIGHT = 12'd320;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Per-step decisions made by the stepper
    typedef struct packed {
        logic at_end;
        logic move_col;
        logic move_row;
    } lr_step_t;

endpackage

// File: hdl/lr_cmd_if.sv
// Command channel into the rasterizer: start and step items.
// Depends on lr_pkg for field widths.
interface lr_cmd_if import lr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [FIELD_BITS-1:0]  start_x;
    logic [FIELD_BITS-1:0]  start_y;
    logic [FIELD_BITS-1:0]  end_x;
    logic [FIELD_BITS-1:0]  end_y;
    logic [COLOUR_BITS-1:0] line_colour;

    modport source (output valid, kind, start_x, start_y, end_x, end_y, line_colour,
                    input ready);
    modport sink   (input valid, kind, start_x, start_y, end_x, end_y, line_colour,
                    output ready);
endinterface

// File: hdl/lr_pix_if.sv
// Pixel channel out of the rasterizer.
// Depends on lr_pkg for field widths.
interface lr_pix_if import lr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FIELD_BITS-1:0]  pixel_x;
    logic [FIELD_BITS-1:0]  pixel_y;
    logic [COLOUR_BITS-1:0] pixel_colour;
    logic                   visible;
    logic                   last;

    modport source (output valid, pixel_x, pixel_y, pixel_colour, visible, last,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_colour, visible, last,
                    output ready);
endinterface

// File: hdl/lr_stepper.sv
// Bresenham step decision and next error/coordinate values.
// Depends on lr_pkg for lr_step_t.
module lr_stepper import lr_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0]   cur_col,
    input  logic [COORD_BITS-1:0]   cur_row,
    input  logic [COORD_BITS-1:0]   target_col,
    input  logic [COORD_BITS-1:0]   target_row,
    input  logic [COORD_BITS-1:0]   abs_dx,
    input  logic signed [COORD_BITS:0]   neg_abs_dy,
    input  logic                    dir_col_neg,
    input  logic                    dir_row_neg,
    input  logic signed [COORD_BITS+1:0] error_term,
    output lr_step_t                step,
    output logic [COORD_BITS-1:0]   col_next,
    output logic [COORD_BITS-1:0]   row_next,
    output logic signed [COORD_BITS+1:0] error_next
);

    logic signed [COORD_BITS+2:0] e2;
    logic signed [COORD_BITS+2:0] ndy_ext;
    logic signed [COORD_BITS+2:0] dx_ext;
    logic signed [COORD_BITS+1:0] add_col;
    logic signed [COORD_BITS+1:0] add_row;

    always_comb
    begin
        e2      = {error_term, 1'b0};
        ndy_ext = {{2{neg_abs_dy[COORD_BITS]}}, neg_abs_dy};
        dx_ext  = $signed({3'b000, abs_dx});

        step.at_end   = (cur_col == target_col) && (cur_row == target_row);
        step.move_col = (e2 >= ndy_ext);
        step.move_row = (e2 <= dx_ext);

        add_col = step.move_col ? {neg_abs_dy[COORD_BITS], neg_abs_dy}
                                : '0;
        add_row = step.move_row ? $signed({2'b00, abs_dx}) : '0;
        error_next = error_term + add_col + add_row;

        if (step.move_col)
            col_next = dir_col_neg ? cur_col - 1'b1 : cur_col + 1'b1;
        else
            col_next = cur_col;

        if (step.move_row)
            row_next = dir_row_neg ? cur_row - 1'b1 : cur_row + 1'b1;
        else
            row_next = cur_row;
    end

endmodule

// File: hdl/line_rasterizer.sv
// Line rasterizer top level: command/pixel channels, screen size registers.
// Depends on lr_pkg, lr_cmd_if, lr_pix_if and lr_stepper.
//
// All-octant Bresenham line rasterizer. A start item (kind 0) latches both
// endpoints and the colour and returns nothing; each step item (kind 1) then
// returns one pixel, flagged visible when it lies inside screen_width by
// screen_height, with last set on the second endpoint, after which steps are
// dropped until the next start. A start in mid-line abandons the old line.
// The step decision and the error/coordinate update run in one pass
// between the line state registers and the pixel output register, so
// a new item is accepted each cycle as long as the output register is
// empty or being drained. Coordinates wrap at COORD_BITS.
module line_rasterizer import lr_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    lr_cmd_if.sink                    cmd,
    lr_pix_if.source                  pix,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    localparam int WIDE = COORD_BITS + FIELD_BITS;

    logic [CFG_BITS-1:0]            width_reg;
    logic [CFG_BITS-1:0]            height_reg;

    logic [COORD_BITS-1:0]          cur_col_reg, cur_col_next;
    logic [COORD_BITS-1:0]          cur_row_reg, cur_row_next;
    logic [COORD_BITS-1:0]          target_col_reg, target_col_next;
    logic [COORD_BITS-1:0]          target_row_reg, target_row_next;
    logic [COORD_BITS-1:0]          abs_dx_reg, abs_dx_next;
    logic signed [COORD_BITS:0]     neg_abs_dy_reg, neg_abs_dy_next;
    logic                           dir_col_neg_reg, dir_col_neg_next;
    logic                           dir_row_neg_reg, dir_row_neg_next;
    logic signed [COORD_BITS+1:0]   error_reg, error_next;
    logic [COLOUR_BITS-1:0]         colour_reg, colour_next;
    logic                           busy_reg, busy_next;

    logic                           out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0]          out_x_reg, out_x_next;
    logic [FIELD_BITS-1:0]          out_y_reg, out_y_next;
    logic [COLOUR_BITS-1:0]         out_colour_reg, out_colour_next;
    logic                           out_visible_reg, out_visible_next;
    logic                           out_last_reg, out_last_next;

    logic                           accept;
    logic                           emit;
    logic [COORD_BITS-1:0]          x0, y0, x1, y1;
    logic [COORD_BITS-1:0]          ady;
    logic [WIDE-1:0]                col_wide, row_wide;

    lr_step_t                       step;
    logic [COORD_BITS-1:0]          step_col, step_row;
    logic signed [COORD_BITS+1:0]   step_error;

    lr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .cur_col     (cur_col_reg),
        .cur_row     (cur_row_reg),
        .target_col  (target_col_reg),
        .target_row  (target_row_reg),
        .abs_dx      (abs_dx_reg),
        .neg_abs_dy  (neg_abs_dy_reg),
        .dir_col_neg (dir_col_neg_reg),
        .dir_row_neg (dir_row_neg_reg),
        .error_term  (error_reg),
        .step        (step),
        .col_next    (step_col),
        .row_next    (step_row),
        .error_next  (step_error)
    );

    assign cmd.ready = !out_valid_reg || pix.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign emit      = accept && (cmd.kind == KIND_STEP) && busy_reg;

    assign pix.valid        = out_valid_reg;
    assign pix.pixel_x      = out_x_reg;
    assign pix.pixel_y      = out_y_reg;
    assign pix.pixel_colour = out_colour_reg;
    assign pix.visible      = out_visible_reg;
    assign pix.last         = out_last_reg;

    // Endpoints taken modulo 2^COORD_BITS
    always_comb
    begin
        x0 = COORD_BITS'(cmd.start_x);
        y0 = COORD_BITS'(cmd.start_y);
        x1 = COORD_BITS'(cmd.end_x);
        y1 = COORD_BITS'(cmd.end_y);
        ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
        col_wide = WIDE'(cur_col_reg);
        row_wide = WIDE'(cur_row_reg);
    end

    always_comb
    begin
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        target_col_next  = target_col_reg;
        target_row_next  = target_row_reg;
        abs_dx_next      = abs_dx_reg;
        neg_abs_dy_next  = neg_abs_dy_reg;
        dir_col_neg_next = dir_col_neg_reg;
        dir_row_neg_next = dir_row_neg_reg;
        error_next       = error_reg;
        colour_next      = colour_reg;
        busy_next        = busy_reg;

        out_valid_next   = out_valid_reg && !pix.ready;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_colour_next  = out_colour_reg;
        out_visible_next = out_visible_reg;
        out_last_next    = out_last_reg;

        if (accept && (cmd.kind == KIND_START))
        begin
            cur_col_next     = x0;
            cur_row_next     = y0;
            target_col_next  = x1;
            target_row_next  = y1;
            abs_dx_next      = (x1 >= x0) ? x1 - x0 : x0 - x1;
            neg_abs_dy_next  = -$signed({1'b0, ady});
            dir_col_neg_next = !(x0 < x1);
            dir_row_neg_next = !(y0 < y1);
            error_next       = $signed({2'b00, abs_dx_next}) - $signed({2'b00, ady});
            colour_next      = cmd.line_colour;
            busy_next        = 1'b1;
        end
        else if (emit)
        begin
            out_valid_next   = 1'b1;
            out_x_next       = col_wide[FIELD_BITS-1:0];
            out_y_next       = row_wide[FIELD_BITS-1:0];
            out_colour_next  = colour_reg;
            out_visible_next = (col_wide < WIDE'(width_reg)) &&
                               (row_wide < WIDE'(height_reg));
            out_last_next    = step.at_end;
            if (step.at_end)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cur_col_next = step_col;
                cur_row_next = step_row;
                error_next   = step_error;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_SCREEN_WIDTH))
                width_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_SCREEN_HEIGHT))
                height_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_col_reg     <= cur_col_next;
        cur_row_reg     <= cur_row_next;
        target_col_reg  <= target_col_next;
        target_row_reg  <= target_row_next;
        abs_dx_reg      <= abs_dx_next;
        neg_abs_dy_reg  <= neg_abs_dy_next;
        dir_col_neg_reg <= dir_col_neg_next;
        dir_row_neg_reg <= dir_row_neg_next;
        error_reg       <= error_next;
        colour_reg      <= colour_next;
        out_x_reg       <= out_x_next;
        out_y_reg       <= out_y_next;
        out_colour_reg  <= out_colour_next;
        out_visible_reg <= out_visible_next;
        out_last_reg    <= out_last_next;
    end

endmodule

// File: hdl/lr_checker.sv
// Port-level checks for line_rasterizer, attached by the bind below.
// Depends on lr_pkg for the item kind codes.
module lr_checker import lr_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic cmd_kind,
    input logic pix_valid,
    input logic pix_ready
);

    // Hold a stalled pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid)
    else $error("pixel dropped while stalled");

    // A full, stalled output register blocks new items
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |-> !cmd_ready)
    else $error("item accepted over a stalled pixel");

    // A new pixel only follows an accepted step item
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !$past(pix_valid) |->
            $past(cmd_valid && cmd_ready && (cmd_kind == KIND_STEP)))
    else $error("pixel without a step item");

    // A start item produces no pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_kind == KIND_START) && (!pix_valid || pix_ready)
            |=> !pix_valid)
    else $error("pixel from a start item");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_kind  (cmd.kind),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready)
);
